// ----- hdl/rrqs_pkg.sv -----
// Shared types and constants of the round-robin quantum scheduler.
package rrqs_pkg;

   localparam int unsigned ID_W     = 8;
   localparam int unsigned TIME_W   = 16;
   localparam int unsigned TICK_W   = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned ENTRY_W  = ID_W + TIME_W;

   // Request opcodes
   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_IDLE     = 3'd0,
      STS_REQUEUED = 3'd1,
      STS_FINISHED = 3'd2,
      STS_QUEUED   = 3'd3,
      STS_FULL     = 3'd4
   } status_type;

   // Controller states
   typedef enum logic {
      S_IDLE,
      S_EXEC
   } rrqs_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic take;    // latch the request and read the queue head
      logic commit;  // update the queue and load the result register
   } rrqs_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free; // result register can take a new item this cycle
   } rrqs_stat_type;

endpackage

// ----- hdl/rrqs_req_if.sv -----
// Request channel: valid/ready handshake with the scheduler request payload.
interface rrqs_req_if;
   import rrqs_pkg::*;

   logic              valid;
   logic              ready;
   logic              opcode;
   logic [ID_W-1:0]   proc_id;
   logic [TIME_W-1:0] burst_time;

   modport source (output valid, opcode, proc_id, burst_time, input ready);
   modport sink   (input valid, opcode, proc_id, burst_time, output ready);
endinterface

// ----- hdl/rrqs_rsp_if.sv -----
// Result channel: valid/ready handshake with the scheduler result payload.
interface rrqs_rsp_if;
   import rrqs_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     run_id;
   logic [TIME_W-1:0]   time_left;
   logic [TICK_W-1:0]   slot_start;

   modport source (output valid, status, run_id, time_left, slot_start, input ready);
   modport sink   (input valid, status, run_id, time_left, slot_start, output ready);
endinterface

// ----- hdl/round_robin_unit_quantum_scheduler.sv -----
// Round-robin scheduler, one-tick quantum. Accepting an item in S_IDLE latches the
// request and registers the queue head read; S_EXEC then commits it, writing back
// the tail and loading the result register. No new request is taken before that
// commit, and a stalled result register holds S_EXEC until it drains.
// Reset (synchronous, active high) clears pointers, occupancy, tick count and result
// valid; queue contents are left as they are and need no clearing pass.
module round_robin_unit_quantum_scheduler #(
   parameter int unsigned QUEUE_DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   rrqs_req_if.sink   req_ch,
   rrqs_rsp_if.source rsp_ch
);
   import rrqs_pkg::*;

   rrqs_cmd_type  cmd;
   rrqs_stat_type stat;

   // Sequence each item
   rrqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .stat      (stat),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   // Queue and result datapath
   rrqs_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_ch.opcode),
      .req_proc_id    (req_ch.proc_id),
      .req_burst_time (req_ch.burst_time),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_status     (rsp_ch.status),
      .rsp_run_id     (rsp_ch.run_id),
      .rsp_time_left  (rsp_ch.time_left),
      .rsp_slot_start (rsp_ch.slot_start)
   );

endmodule

// ----- hdl/rrqs_ctrl.sv -----
// Controller state machine: sequences accept, head read and commit of one item.
module rrqs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  rrqs_pkg::rrqs_stat_type stat,
   output logic                   req_ready,
   output rrqs_pkg::rrqs_cmd_type  cmd
);
   import rrqs_pkg::*;

   rrqs_state_type state_ff;
   rrqs_state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd.take   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            cmd.take  = !reset && req_valid;
         end
         S_EXEC: begin
            cmd.commit = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- hdl/rrqs_datapath.sv -----
// Datapath: ready queue memory, pointers, tick counter and result register.
module rrqs_datapath #(
   parameter int unsigned QUEUE_DEPTH = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rrqs_pkg::rrqs_cmd_type          cmd,
   output rrqs_pkg::rrqs_stat_type         stat,
   input  logic                            req_opcode,
   input  logic [rrqs_pkg::ID_W-1:0]       req_proc_id,
   input  logic [rrqs_pkg::TIME_W-1:0]     req_burst_time,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rrqs_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rrqs_pkg::ID_W-1:0]       rsp_run_id,
   output logic [rrqs_pkg::TIME_W-1:0]     rsp_time_left,
   output logic [rrqs_pkg::TICK_W-1:0]     rsp_slot_start
);
   import rrqs_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] idx);
      next_idx = (idx == LAST_IDX) ? '0 : idx + PTR_W'(1);
   endfunction

   // Queue storage and read register
   logic [ENTRY_W-1:0] fifo_mem_ff [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Control state
   logic [PTR_W-1:0]  head_ptr_ff, head_ptr_in;
   logic [PTR_W-1:0]  tail_ptr_ff, tail_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Latched request
   logic              op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] burst_ff;

   // Result register
   status_type        sts_ff, sts_in;
   logic [ID_W-1:0]   run_id_ff, run_id_in;
   logic [TIME_W-1:0] left_ff, left_in;
   logic [TICK_W-1:0] start_ff;

   logic               push, pop;
   logic [ENTRY_W-1:0] push_data;
   logic [ID_W-1:0]    head_id;
   logic [TIME_W-1:0]  head_rem, head_dec;
   logic               empty, full;

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign head_id  = rd_data_ff[ENTRY_W-1:TIME_W];
   assign head_rem = rd_data_ff[TIME_W-1:0];
   assign head_dec = (head_rem == '0) ? '0 : head_rem - TIME_W'(1);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FULL_CNT);

   // Latch the request, normalising a zero burst to one
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff    <= req_opcode;
         id_ff    <= req_proc_id;
         burst_ff <= (req_burst_time == '0) ? TIME_W'(1) : req_burst_time;
      end
   end

   // Queue memory: append at the tail, read the head on accept
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem_ff[tail_ptr_ff] <= push_data;
      end
      if (cmd.take) begin
         rd_data_ff <= fifo_mem_ff[head_ptr_ff];
      end
   end

   // Decide the outcome of the item
   always_comb begin
      push      = 1'b0;
      pop       = 1'b0;
      push_data = {id_ff, burst_ff};
      sts_in    = STS_IDLE;
      run_id_in = '0;
      left_in   = '0;
      tick_in   = tick_ff;
      if (op_ff == OP_ARRIVE) begin
         run_id_in = id_ff;
         left_in   = burst_ff;
         if (full) begin
            sts_in = STS_FULL;
         end else begin
            sts_in = STS_QUEUED;
            push   = cmd.commit;
         end
      end else begin
         tick_in = tick_ff + TICK_W'(1);
         if (!empty) begin
            pop       = cmd.commit;
            run_id_in = head_id;
            push_data = {head_id, head_dec};
            if (head_dec == '0) begin
               sts_in = STS_FINISHED;
            end else begin
               sts_in  = STS_REQUEUED;
               left_in = head_dec;
               push    = cmd.commit;
            end
         end
      end
   end

   // Advance pointers and occupancy
   always_comb begin
      head_ptr_in = pop ? next_idx(head_ptr_ff) : head_ptr_ff;
      tail_ptr_in = push ? next_idx(tail_ptr_ff) : tail_ptr_ff;
      count_in    = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Result valid: load on commit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff  <= '0;
         tail_ptr_ff  <= '0;
         count_ff     <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            tick_ff <= tick_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         sts_ff    <= sts_in;
         run_id_ff <= run_id_in;
         left_ff   <= left_in;
         start_ff  <= tick_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = sts_ff;
   assign rsp_run_id     = run_id_ff;
   assign rsp_time_left  = left_ff;
   assign rsp_slot_start = start_ff;

endmodule

// ----- hdl/rrqs_checker.sv -----
// Port-level assertions for the scheduler, bound to the top level.
module rrqs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rrqs_pkg::STATUS_W-1:0] rsp_status,
   input logic [rrqs_pkg::ID_W-1:0]     rsp_run_id,
   input logic [rrqs_pkg::TIME_W-1:0]   rsp_time_left,
   input logic [rrqs_pkg::TICK_W-1:0]   rsp_slot_start
);
   import rrqs_pkg::*;

   // One item in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous item still in work");

   // Stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_run_id) && $stable(rsp_time_left) && $stable(rsp_slot_start)))
      else $error("stalled result changed");

   // Idle tick reports no process
   a_idle_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STS_IDLE) |-> (rsp_run_id == '0 && rsp_time_left == '0))
      else $error("idle result carries a process");

   // Queued, dropped or requeued process always has time left
   a_time_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STS_QUEUED || rsp_status == STS_FULL ||
         rsp_status == STS_REQUEUED)) |-> (rsp_time_left != '0))
      else $error("live process reported with no time left");

endmodule

bind round_robin_unit_quantum_scheduler rrqs_checker u_rrqs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_run_id     (rsp_ch.run_id),
   .rsp_time_left  (rsp_ch.time_left),
   .rsp_slot_start (rsp_ch.slot_start)
);

// ----- bench/testbench.sv -----
// Self-checking bench for the round-robin scheduler: directed, queue-full and random traffic.
module testbench;
   import rrqs_pkg::*;

   localparam int unsigned QDEPTH = 128;

   // One queued process as the scheduler keeps it
   typedef struct {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] remaining;
   } proc_entry_type;

   // One scheduler outcome as it leaves the result channel
   typedef struct {
      status_type        status;
      logic [ID_W-1:0]   run_id;
      logic [TIME_W-1:0] time_left;
      logic [TICK_W-1:0] slot_start;
   } sched_outcome_type;

   logic clock = 1'b0;
   logic reset;

   rrqs_req_if req_ch ();
   rrqs_rsp_if rsp_ch ();

   round_robin_unit_quantum_scheduler #(
      .QUEUE_DEPTH(QDEPTH)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // Predicted scheduler state and pending outcomes
   proc_entry_type    ready_procs[$];
   sched_outcome_type expected_outcomes[$];
   logic [TICK_W-1:0] tick_counter = '0;
   int unsigned       error_count  = 0;
   bit                quiet_mode   = 1'b0;

   // Free-running clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hold-off length: mostly none or short, now and then long
   function automatic int unsigned gap_len();
      int unsigned r;
      if (quiet_mode) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Burst lengths: mostly short so that processes finish, a few across the whole range
   function automatic logic [TIME_W-1:0] pick_burst();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return '0;
      end else if (r < 75) begin
         return TIME_W'($urandom_range(1, 4));
      end else if (r < 97) begin
         return TIME_W'($urandom_range(5, 40));
      end
      return TIME_W'($urandom);
   endfunction

   // Advance the predicted scheduler by one accepted item and queue the outcome
   function automatic void schedule_step(logic op, logic [ID_W-1:0] id,
                                         logic [TIME_W-1:0] burst);
      sched_outcome_type res;
      proc_entry_type    head;
      logic [TIME_W-1:0] need;
      res.slot_start = tick_counter;
      if (op == OP_ARRIVE) begin
         need          = (burst == '0) ? TIME_W'(1) : burst;
         res.run_id    = id;
         res.time_left = need;
         if (ready_procs.size() >= QDEPTH) begin
            res.status = STS_FULL;
         end else begin
            ready_procs.push_back('{id, need});
            res.status = STS_QUEUED;
         end
      end else begin
         tick_counter = tick_counter + 1'b1;
         if (ready_procs.size() == 0) begin
            res.status    = STS_IDLE;
            res.run_id    = '0;
            res.time_left = '0;
         end else begin
            head       = ready_procs.pop_front();
            res.run_id = head.id;
            if (head.remaining > 1) begin
               head.remaining = head.remaining - 1'b1;
               ready_procs.push_back(head);
               res.status    = STS_REQUEUED;
               res.time_left = head.remaining;
            end else begin
               res.status    = STS_FINISHED;
               res.time_left = '0;
            end
         end
      end
      expected_outcomes.push_back(res);
   endfunction

   // Count a failure; report only the first few
   function automatic void report_error(string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("error at %0t: %s", $time, msg);
      end
   endfunction

   // Offer one item after a random hold-off and predict it once accepted
   task automatic send_item(logic op, logic [ID_W-1:0] id, logic [TIME_W-1:0] burst);
      int unsigned gap;
      gap = gap_len();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.proc_id    <= id;
      req_ch.burst_time <= burst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      schedule_step(op, id, burst);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, ID_W'($urandom), TIME_W'($urandom));
   endtask

   // Idle ticks, zero burst, extreme ids and bursts, requeue and finish
   task automatic test_directed_cases();
      send_item(OP_TICK, '0, '0);
      send_item(OP_TICK, '1, '1);
      send_item(OP_ARRIVE, 8'h00, 16'h0000);
      send_item(OP_ARRIVE, 8'hFF, 16'hFFFF);
      send_item(OP_ARRIVE, 8'hA5, 16'h0001);
      send_item(OP_ARRIVE, 8'h5A, 16'h0002);
      send_item(OP_ARRIVE, 8'h3C, 16'h8000);
      send_item(OP_ARRIVE, 8'hC3, 16'h7FFE);
      repeat (10) send_tick();
      send_item(OP_ARRIVE, 8'h01, 16'h0003);
      repeat (4) send_tick();
   endtask

   // Fill the queue, hit it while full, requeue at full, then drain the short ones
   task automatic test_queue_overflow();
      while (ready_procs.size() < QDEPTH) begin
         send_item(OP_ARRIVE, ID_W'($urandom), TIME_W'($urandom_range(1, 3)));
      end
      send_item(OP_ARRIVE, 8'hFF, 16'hFFFF);
      send_item(OP_ARRIVE, 8'h00, 16'h0000);
      repeat (3) send_item(OP_ARRIVE, ID_W'($urandom), pick_burst());
      send_tick();
      send_item(OP_ARRIVE, ID_W'($urandom), pick_burst());
      send_item(OP_ARRIVE, ID_W'($urandom), pick_burst());
      repeat (400) send_tick();
   endtask

   // Random traffic in segments that swing between filling and draining the queue
   task automatic test_random_traffic(int unsigned count);
      int unsigned arrive_pct;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 150 == 0) begin
            arrive_pct = ((i / 150) % 2 == 0) ? 75 : 30;
            quiet_mode = ((i / 150) % 3 == 2);
         end
         if ($urandom_range(0, 99) < arrive_pct) begin
            send_item(OP_ARRIVE, ID_W'($urandom), pick_burst());
         end else begin
            send_tick();
         end
      end
      quiet_mode = 1'b0;
   endtask

   // Result side: random back-pressure
   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = gap_len();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      sched_outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_outcomes.size() == 0) begin
            report_error($sformatf("unexpected result status %0d id %0d left %0d slot %0d",
                                   rsp_ch.status, rsp_ch.run_id, rsp_ch.time_left,
                                   rsp_ch.slot_start));
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.run_id !== want.run_id ||
                rsp_ch.time_left !== want.time_left ||
                rsp_ch.slot_start !== want.slot_start) begin
               report_error($sformatf({"expected status %0d id %0d left %0d slot %0d, ",
                                       "got status %0d id %0d left %0d slot %0d"},
                                      want.status, want.run_id, want.time_left,
                                      want.slot_start, rsp_ch.status, rsp_ch.run_id,
                                      rsp_ch.time_left, rsp_ch.slot_start));
            end
         end
      end
   end

   // Run limit
   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Test sequence
   initial begin
      int unsigned settle;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.opcode     <= OP_ARRIVE;
      req_ch.proc_id    <= '0;
      req_ch.burst_time <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_queue_overflow();
      test_random_traffic(1500);
      req_ch.valid <= 1'b0;

      // Drain outstanding results, then allow for the pipeline to settle
      settle = 0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      while (settle < 10) begin
         @(posedge clock);
         settle++;
      end
      if (error_count == 0 && expected_outcomes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
